### rtl/rcm_pkg.sv
// shared constants and codes of the raycast column texel mapper
// no dependencies, imported by every module of the block
`default_nettype none

package rcm_pkg;

   // screen and texture limits
   localparam int SCREEN_ROWS = 1024;
   localparam int TEXTURE_MAX = 1024;

   // field widths
   localparam int ROW_W    = 10;
   localparam int COL_W    = 11;
   localparam int DIR_W    = 20;
   localparam int POS_W    = 26;
   localparam int LH_W     = 20;
   localparam int BOUND_W  = 11;
   localparam int TEX_W    = 11;
   localparam int TEXEL_W  = 10;
   localparam int INDEX_W  = 20;
   localparam int COLOUR_W = 24;
   localparam int FRAC_W   = 16;
   localparam int ACC_W    = 32;
   localparam int TX_ST_W  = 12;

   // divider: (height << 16) / projected wall rows
   localparam int DIV_W = TEX_W + FRAC_W;

   // shared multiplier operand widths
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 21;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // stream widths
   localparam int REQ_DATA_W = 184;
   localparam int RSP_DATA_W = 88;
   localparam int RSP_USER_W = 2;

   // pixel kinds
   localparam logic [1:0] KIND_CEILING  = 2'd0;
   localparam logic [1:0] KIND_WALL     = 2'd1;
   localparam logic [1:0] KIND_FLOOR    = 2'd2;
   localparam logic [1:0] KIND_NO_WRITE = 2'd3;

   // wall faces
   localparam logic [1:0] FACE_HORZ_NEG = 2'd0;
   localparam logic [1:0] FACE_HORZ_POS = 2'd1;
   localparam logic [1:0] FACE_VERT_POS = 2'd2;
   localparam logic [1:0] FACE_VERT_NEG = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_FLOOR_COLOUR   = 2'd0;
   localparam logic [1:0] CSR_CEILING_COLOUR = 2'd1;
   localparam logic [1:0] CSR_TEXTURE_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_TEXTURE_HEIGHT = 2'd3;

endpackage

`default_nettype wire

### rtl/raycast_column_texel_mapper_unit.sv
// top level of the raycast column texel mapper: sequencer, column state, output register
// depends on rcm_pkg, rcm_mul and rcm_div
//
//  channel | dir | transfer when          | payload
//  --------+-----+------------------------+-------------------------------------------
//  req     | in  | req_tvalid & req_tready| one screen pixel with the column hit data
//  rsp     | out | rsp_tvalid & rsp_tready| pixel kind, face, texel coordinates, colour
//  csr     | in  | csr_we                 | colours and texture size, idle writes only
//
//  row 0: the shared multiplier gives the wall hit and the texel column, then the
//  one-bit-per-cycle step divider gives the texel step; the rest is as for other rows
//  other rows: classify, then load the output (a wall texel passes an index step first, whose index
//  reuses the multiplier); req_tready comes back in the same cycle the result turns valid
//  a stalled result holds the output register; the next pixel is accepted and waits
//  reset is synchronous; clears control and column state (not frac) and colours, sets tex size 64
`default_nettype none

module raycast_column_texel_mapper_unit
   import rcm_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // req_tdata: row, column, ray_dir_x, ray_dir_y, player_x, player_y,
   //            perp_distance, wall rows, first wall row, row after the wall, zero fill
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: hit_side
   input  wire logic                   req_tuser,
   // rsp_tdata: out_column, out_row, face_index, texel_x, texel_y, texel_index,
   //            fill_colour, zero fill
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]       rsp_tdata,
   // rsp_tuser: pixel_kind
   output logic [RSP_USER_W-1:0]       rsp_tuser,
   // register write port
   input  wire logic                   csr_we,
   input  wire logic [1:0]             csr_index,
   input  wire logic [COLOUR_W-1:0]    csr_wdata
);

   // sequencer states
   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_HIT      = 3'd1;
   localparam logic [2:0] ST_FRAC     = 3'd2;
   localparam logic [2:0] ST_TEX_MUL  = 3'd3;
   localparam logic [2:0] ST_TEX_X    = 3'd4;
   localparam logic [2:0] ST_DIV      = 3'd5;
   localparam logic [2:0] ST_CLASSIFY = 3'd6;
   localparam logic [2:0] ST_INDEX    = 3'd7;
   // output hand-off happens in idle-bound state below
   localparam logic [3:0] ST_OUT_CODE = 4'd8;

   logic [3:0] state_ff, state_in;

   // configuration registers
   logic [COLOUR_W-1:0] floor_ff, ceiling_ff;
   logic [TEX_W-1:0]    tex_w_ff, tex_h_ff;
   logic [TEX_W-1:0]    w_sat, h_sat;

   // latched item
   logic [ROW_W-1:0]         row_ff;
   logic [COL_W-1:0]         column_ff;
   logic                     side_ff;
   logic signed [DIR_W-1:0]  rdx_ff, rdy_ff;
   logic [POS_W-1:0]         px_ff, py_ff, perp_ff;
   logic [LH_W-1:0]          lh_ff;
   logic [BOUND_W-1:0]       ds_ff, de_ff;

   // column state
   logic [ACC_W-1:0]   step_ff, step_in;
   logic [ACC_W-1:0]   pos_ff, pos_in;
   logic [TX_ST_W-1:0] ctx_ff, ctx_in;
   logic [1:0]         face_ff, face_in;
   logic [ACC_W-1:0]   frac_ff, frac_in;

   // result being built
   logic [1:0]          kind_ff, kind_in;
   logic [TEXEL_W-1:0]  tx_ff, tx_in, ty_ff, ty_in;
   logic [INDEX_W-1:0]  idx_ff, idx_in;
   logic [COLOUR_W-1:0] fill_ff, fill_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic [RSP_USER_W-1:0] rsp_user_ff, rsp_user_in;

   // shared units
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] prod_ff;
   logic                      div_start;
   logic [DIV_W-1:0]          div_quo;
   logic                      div_done;

   // helpers
   logic                 req_xfer;
   logic [POS_W-1:0]     p_sel;
   logic [BOUND_W-1:0]   row_ext;
   logic [FRAC_W-1:0]    ty_raw;
   logic [TEXEL_W-1:0]   ty_clamp;
   logic [ACC_W:0]       pos_sum;
   logic                 wall_ok;

   rcm_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   rcm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({h_sat, FRAC_W'(0)}),
      .divisor  (lh_ff),
      .quo_ff   (div_quo),
      .done_ff  (div_done)
   );

   assign req_tready = (state_ff == {1'b0, ST_IDLE});
   assign req_xfer   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // texture size saturates to the supported maximum
   assign w_sat = (tex_w_ff > TEX_W'(TEXTURE_MAX)) ? TEX_W'(TEXTURE_MAX) : tex_w_ff;
   assign h_sat = (tex_h_ff > TEX_W'(TEXTURE_MAX)) ? TEX_W'(TEXTURE_MAX) : tex_h_ff;

   // vertical side hit uses the y position, horizontal side the x position
   assign p_sel   = side_ff ? px_ff : py_ff;
   assign row_ext = {1'b0, row_ff};
   assign ty_raw  = pos_ff[ACC_W-1:FRAC_W];
   assign ty_clamp = (ty_raw >= FRAC_W'(h_sat)) ? TEXEL_W'(h_sat - TEX_W'(1))
                                                : ty_raw[TEXEL_W-1:0];
   assign pos_sum = {1'b0, pos_ff} + {1'b0, step_ff};
   assign wall_ok = (ctx_ff < TX_ST_W'(w_sat)) && (h_sat != '0);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      pos_in       = pos_ff;
      ctx_in       = ctx_ff;
      face_in      = face_ff;
      frac_in      = frac_ff;
      kind_in      = kind_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      idx_in       = idx_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      mul_a        = '0;
      mul_b        = '0;
      div_start    = 1'b0;

      // result taken downstream
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         {1'b0, ST_IDLE}: begin
            if (req_xfer) begin
               if (req_tdata[ROW_W-1:0] == '0) begin
                  state_in = {1'b0, ST_HIT};
               end else begin
                  state_in = {1'b0, ST_CLASSIFY};
               end
            end
         end
         {1'b0, ST_HIT}: begin
            // perp_distance times the ray component along the wall
            mul_a = MUL_A_W'(perp_ff);
            mul_b = side_ff ? MUL_B_W'(rdx_ff) : MUL_B_W'(rdy_ff);
            if (!side_ff) begin
               face_in = (!rdx_ff[DIR_W-1] && rdx_ff != '0) ? FACE_VERT_POS : FACE_VERT_NEG;
            end else begin
               face_in = (!rdy_ff[DIR_W-1] && rdy_ff != '0) ? FACE_HORZ_POS : FACE_HORZ_NEG;
            end
            state_in = {1'b0, ST_FRAC};
         end
         {1'b0, ST_FRAC}: begin
            // low 32 bits of the hit point give the wall fraction (floor rule)
            frac_in  = {p_sel[FRAC_W-1:0], FRAC_W'(0)} + prod_ff[ACC_W-1:0];
            state_in = {1'b0, ST_TEX_MUL};
         end
         {1'b0, ST_TEX_MUL}: begin
            mul_a    = MUL_A_W'(frac_ff);
            mul_b    = MUL_B_W'(w_sat);
            state_in = {1'b0, ST_TEX_X};
         end
         {1'b0, ST_TEX_X}: begin
            ctx_in    = prod_ff[ACC_W+TX_ST_W-1:ACC_W];
            div_start = 1'b1;
            state_in  = {1'b0, ST_DIV};
         end
         {1'b0, ST_DIV}: begin
            if (div_done) begin
               // zero line height saturates the step
               step_in  = (lh_ff == '0) ? '1 : ACC_W'(div_quo);
               pos_in   = '0;
               state_in = {1'b0, ST_CLASSIFY};
            end
         end
         {1'b0, ST_CLASSIFY}: begin
            tx_in    = '0;
            ty_in    = '0;
            idx_in   = '0;
            fill_in  = '0;
            state_in = ST_OUT_CODE;
            // texel row times width for the index, used only by wall rows
            mul_a    = MUL_A_W'(ty_clamp);
            mul_b    = MUL_B_W'(w_sat);
            if (row_ext >= BOUND_W'(SCREEN_ROWS)) begin
               kind_in = KIND_NO_WRITE;
            end else if (row_ext < ds_ff) begin
               kind_in = KIND_CEILING;
               fill_in = ceiling_ff;
            end else if (row_ext >= de_ff) begin
               kind_in = KIND_FLOOR;
               fill_in = floor_ff;
            end else if (!wall_ok) begin
               kind_in = KIND_NO_WRITE;
            end else begin
               kind_in  = KIND_WALL;
               tx_in    = ctx_ff[TEXEL_W-1:0];
               ty_in    = ty_clamp;
               state_in = {1'b0, ST_INDEX};
            end
         end
         {1'b0, ST_INDEX}: begin
            idx_in   = prod_ff[INDEX_W-1:0] + INDEX_W'(tx_ff);
            // running position saturates at all ones
            pos_in   = pos_sum[ACC_W] ? '1 : pos_sum[ACC_W-1:0];
            state_in = ST_OUT_CODE;
         end
         ST_OUT_CODE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_user_in  = kind_ff;
               rsp_data_in  = {1'b0, fill_ff, idx_ff, ty_ff, tx_ff, face_ff, row_ff,
                               column_ff};
               state_in     = {1'b0, ST_IDLE};
            end
         end
         default: begin
            state_in = {1'b0, ST_IDLE};
         end
      endcase
   end

   // control, column state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= {1'b0, ST_IDLE};
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
         pos_ff       <= '0;
         ctx_ff       <= '0;
         face_ff      <= FACE_HORZ_NEG;
         floor_ff     <= '0;
         ceiling_ff   <= '0;
         tex_w_ff     <= TEX_W'(64);
         tex_h_ff     <= TEX_W'(64);
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         step_ff      <= step_in;
         pos_ff       <= pos_in;
         ctx_ff       <= ctx_in;
         face_ff      <= face_in;
         if (csr_we) begin
            case (csr_index)
               CSR_FLOOR_COLOUR:   floor_ff   <= csr_wdata;
               CSR_CEILING_COLOUR: ceiling_ff <= csr_wdata;
               CSR_TEXTURE_WIDTH:  tex_w_ff   <= csr_wdata[TEX_W-1:0];
               CSR_TEXTURE_HEIGHT: tex_h_ff   <= csr_wdata[TEX_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      frac_ff     <= frac_in;
      kind_ff     <= kind_in;
      tx_ff       <= tx_in;
      ty_ff       <= ty_in;
      idx_ff      <= idx_in;
      fill_ff     <= fill_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      if (req_xfer) begin
         row_ff    <= req_tdata[9:0];
         column_ff <= req_tdata[20:10];
         rdx_ff    <= req_tdata[40:21];
         rdy_ff    <= req_tdata[60:41];
         px_ff     <= req_tdata[86:61];
         py_ff     <= req_tdata[112:87];
         perp_ff   <= req_tdata[138:113];
         lh_ff     <= req_tdata[158:139];
         ds_ff     <= req_tdata[169:159];
         de_ff     <= req_tdata[180:170];
         side_ff   <= req_tuser;
      end
   end

endmodule

`default_nettype wire

### rtl/rcm_mul.sv
// shared signed multiplier with registered product
// depends on rcm_pkg for operand widths
`default_nettype none

module rcm_mul
   import rcm_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic signed [MUL_A_W-1:0]  mul_a,
   input  wire logic signed [MUL_B_W-1:0]  mul_b,
   output logic signed [MUL_P_W-1:0]       prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
   end

endmodule

`default_nettype wire

### rtl/rcm_div.sv
// restoring divider, one quotient bit per cycle
// depends on rcm_pkg for widths
`default_nettype none

module rcm_div
   import rcm_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [DIV_W-1:0]  dividend,
   input  wire logic [LH_W-1:0]   divisor,
   output logic [DIV_W-1:0]       quo_ff,
   output logic                   done_ff
);

   localparam int CNT_W = $clog2(DIV_W + 1);

   logic             busy_ff, busy_in;
   logic             done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LH_W-1:0]  rem_ff, rem_in;
   logic [DIV_W-1:0] quo_in;
   logic [LH_W:0]    shifted;
   logic [LH_W+1:0]  diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[DIV_W-1]};
      diff    = {1'b0, shifted} - {2'b00, divisor};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIV_W);
         rem_in  = '0;
         quo_in  = dividend;
      end else if (busy_ff) begin
         // trial subtract of the divisor from the shifted remainder
         if (!diff[LH_W+1]) begin
            rem_in = diff[LH_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = shifted[LH_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

endmodule

`default_nettype wire

### rtl/rcm_checker.sv
// port-level checks of the raycast column texel mapper, bound to the top level
// depends on rcm_pkg and raycast_column_texel_mapper_unit
`default_nettype none

module rcm_checker
   import rcm_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_tvalid,
   input wire logic                   req_tready,
   input wire logic                   rsp_tvalid,
   input wire logic                   rsp_tready,
   input wire logic [RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic [RSP_USER_W-1:0]  rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // one pixel in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("accepted a pixel while busy");

   // texel fields are zero unless the pixel is a wall texel
   a_texel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_WALL |-> rsp_tdata[62:23] == '0)
      else $error("texel fields set on a non-wall pixel");

   // fill colour only on ceiling and floor
   a_fill_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_WALL || rsp_tuser == KIND_NO_WRITE)
      |-> rsp_tdata[86:63] == '0)
      else $error("fill colour set on a wall or no-write pixel");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind raycast_column_texel_mapper_unit rcm_checker u_rcm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
